// ----- src/oeq_pkg.sv -----
// Shared types and constants for the ordered entry queue with match.
// No dependencies; used by oeq_cell and ordered_entry_queue_with_match.
package oeq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FIELD_W     = 8;

  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [FIELD_W-1:0] field_t;

  // Command codes carried on in_command
  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_POP      = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_CONTAINS = 2'd3
  } cmd_t;

  // Result codes carried on out_status
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // One queue entry
  typedef struct packed {
    field_t proc;
    field_t page;
    field_t frame;
  } entry_t;

  // Per-cell control, broadcast from the top level
  typedef struct packed {
    logic   fire;      // a command beat is accepted this cycle
    cmd_t   op;
    entry_t key;
    logic   occupied;  // this cell lies below the entry count
    logic   load;      // this cell is the tail slot for an add
  } cell_ctrl_t;

  // Per-cell report back to the top level
  typedef struct packed {
    logic   frame_hit; // occupied and frame equals the key frame
    field_t taken;     // frame of the entry removed here, else zero
  } cell_stat_t;

endpackage

// ----- src/oeq_cell.sv -----
// One storage cell of the queue chain: holds an entry, compares it with the key
// and shifts toward the head when the gap-closing chain reaches it. Uses oeq_pkg.
module oeq_cell
  import oeq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     next_entry,  // entry held by the neighbour towards the tail
  input  logic       shift_in,    // gap opened at or before the previous cell
  output logic       shift_out,
  output entry_t     entry,
  output cell_stat_t stat
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   hit;

  // Match on all three fields for remove
  assign hit = ctrl.fire && (ctrl.op == CMD_REMOVE) && ctrl.occupied &&
               (entry_r == ctrl.key);

  // Extend the gap-closing chain
  assign shift_out = shift_in | hit;

  assign stat.frame_hit = ctrl.occupied && (entry_r.frame == ctrl.key.frame);
  assign stat.taken     = (hit && !shift_in) ? entry_r.frame : '0;
  assign entry          = entry_r;

  // Shift, load or hold
  always_comb begin
    entry_nxt = entry_r;
    if (shift_out) begin
      entry_nxt = next_entry;
    end else if (ctrl.load) begin
      entry_nxt = ctrl.key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- src/ordered_entry_queue_with_match.sv -----
// Top level of the ordered entry queue with match: a chain of oeq_cell stages,
// the entry count and the result register. Uses oeq_pkg and oeq_cell.
//
//   channel | ports                                           | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid/in_ready, command, proc, page, frame    | in
//   out     | out_valid/out_ready, status, removed, occupancy  | out
//
// Every command is handled in the cycle it is accepted: all cells compare in parallel and
// the gap-closing chain shifts every cell behind the gap in the same edge.
// The result is held in an output register; a new beat is taken whenever that
// register is empty or being drained, so one command per cycle is sustained while out_ready stays high.
// Reset clears the entry count and the output valid; cell contents are
// not cleared, as only cells below the count are ever read.
module ordered_entry_queue_with_match
  import oeq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_proc_index,
  input  logic [7:0] in_page_number,
  input  logic [7:0] in_frame_number,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_removed_frame,
  output logic [4:0] out_occupancy
);

  logic       fire;
  cmd_t       op;
  entry_t     key;
  count_t     count_r, count_nxt;
  logic       out_valid_r;
  status_t    status_r, status_nxt;
  field_t     removed_r, removed_nxt;
  count_t     occ_r;

  cell_ctrl_t ctrl   [QUEUE_DEPTH];
  cell_stat_t stat   [QUEUE_DEPTH];
  entry_t     entries[QUEUE_DEPTH];
  logic       chain  [QUEUE_DEPTH+1];

  logic       any_frame;
  field_t     taken_or;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign op       = cmd_t'(in_command);
  assign key      = '{proc: in_proc_index, page: in_page_number, frame: in_frame_number};

  // Pop starts the shift chain at the head
  assign chain[0] = fire && (op == CMD_POP) && (count_r != '0);

  // Build the row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    always_comb begin
      ctrl[i].fire     = fire;
      ctrl[i].op       = op;
      ctrl[i].key      = key;
      ctrl[i].occupied = count_t'(i) < count_r;
      ctrl[i].load     = fire && (op == CMD_ADD) && (count_t'(i) == count_r);
    end

    oeq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .next_entry ((i == QUEUE_DEPTH - 1) ? entries[i] : entries[(i + 1) % QUEUE_DEPTH]),
      .shift_in   (chain[i]),
      .shift_out  (chain[i+1]),
      .entry      (entries[i]),
      .stat       (stat[i])
    );
  end

  // Gather the per-cell reports
  always_comb begin
    any_frame = 1'b0;
    taken_or  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      any_frame = any_frame | stat[i].frame_hit;
      taken_or  = taken_or | stat[i].taken;
    end
  end

  // Work out the new count and result
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_NOTFOUND;
    removed_nxt = '0;
    case (op)
      CMD_ADD: begin
        if (count_r < count_t'(QUEUE_DEPTH)) begin
          count_nxt  = count_r + count_t'(1);
          status_nxt = ST_DONE;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      CMD_POP: begin
        if (count_r != '0) begin
          count_nxt  = count_r - count_t'(1);
          status_nxt = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        if (chain[QUEUE_DEPTH]) begin
          count_nxt   = count_r - count_t'(1);
          status_nxt  = ST_DONE;
          removed_nxt = taken_or;
        end
      end
      CMD_CONTAINS: begin
        if (any_frame) begin
          status_nxt = ST_DONE;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Hold count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      occ_r     <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_frame = removed_r;
  assign out_occupancy     = 5'(occ_r);

endmodule

// ----- tb/sv/tb_ordered_entry_queue_with_match.sv -----
// Self-checking bench for ordered_entry_queue_with_match: a directed plan, then random
// add/pop/remove/contains traffic scored against an in-bench queue predictor.
// Depends on oeq_pkg and the ordered_entry_queue_with_match RTL.
`timescale 1ns / 1ps

module tb_ordered_entry_queue_with_match;
  import oeq_pkg::*;

  localparam int RANDOM_ITEMS = 1920;
  localparam int HOLD_OFF     = 120;   // receiver stall, in cycles
  localparam int STUCK_LIMIT  = 1000;  // cycles with no beat before giving up
  localparam int HOLD_AT      = 400;
  localparam int PAUSE_AT     = 700;
  localparam int CALM_FROM    = 900;
  localparam int CALM_TO      = 1250;

  typedef struct packed {
    status_t    status;
    field_t     removed;
    logic [4:0] occ;
  } result_t;

  typedef struct packed {
    cmd_t       op;
    entry_t     e;
    logic [4:0] reps;
    logic       typed;
    result_t    want;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_command;
  logic [7:0] in_proc_index;
  logic [7:0] in_page_number;
  logic [7:0] in_frame_number;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [7:0] out_removed_frame;
  logic [4:0] out_occupancy;

  // typed expectation travelling alongside the beat on offer
  logic    row_typed;
  result_t row_want;

  entry_t  held[$];
  result_t pending_results[$];
  int      errors;
  int      n_offered;
  bit      calm;
  int      idle_cycles;
  int      n_cmds, n_full, n_rm_hit, n_rm_miss, n_has_hit, n_empty_pop;

  // Directed plan: empty queue, field extremes, fill to full, misses and hits
  row_t plan [17] = '{
    '{CMD_POP,      24'h000000, 5'd1,  1'b1, '{ST_NOTFOUND, 8'h00, 5'd0}},
    '{CMD_REMOVE,   24'hffffff, 5'd1,  1'b1, '{ST_NOTFOUND, 8'h00, 5'd0}},
    '{CMD_CONTAINS, 24'h000000, 5'd1,  1'b1, '{ST_NOTFOUND, 8'h00, 5'd0}},
    '{CMD_ADD,      24'h000000, 5'd1,  1'b1, '{ST_DONE,     8'h00, 5'd1}},
    '{CMD_ADD,      24'hffffff, 5'd1,  1'b1, '{ST_DONE,     8'h00, 5'd2}},
    '{CMD_ADD,      24'ha55a3c, 5'd14, 1'b0, '{ST_DONE,     8'h00, 5'd0}},
    '{CMD_ADD,      24'h123456, 5'd1,  1'b1, '{ST_FULL,     8'h00, 5'd16}},
    '{CMD_CONTAINS, 24'h000056, 5'd1,  1'b1, '{ST_NOTFOUND, 8'h00, 5'd16}},
    '{CMD_CONTAINS, 24'h0000ff, 5'd1,  1'b1, '{ST_DONE,     8'h00, 5'd16}},
    '{CMD_REMOVE,   24'hffff00, 5'd1,  1'b1, '{ST_NOTFOUND, 8'h00, 5'd16}},
    '{CMD_REMOVE,   24'h00ffff, 5'd1,  1'b1, '{ST_NOTFOUND, 8'h00, 5'd16}},
    '{CMD_REMOVE,   24'hffffff, 5'd1,  1'b1, '{ST_DONE,     8'hff, 5'd15}},
    '{CMD_REMOVE,   24'ha55a3c, 5'd1,  1'b1, '{ST_DONE,     8'h3c, 5'd14}},
    '{CMD_CONTAINS, 24'h00003c, 5'd1,  1'b1, '{ST_DONE,     8'h00, 5'd14}},
    '{CMD_POP,      24'h000000, 5'd1,  1'b1, '{ST_DONE,     8'h00, 5'd13}},
    '{CMD_CONTAINS, 24'h000000, 5'd1,  1'b1, '{ST_NOTFOUND, 8'h00, 5'd13}},
    '{CMD_ADD,      24'h010203, 5'd1,  1'b1, '{ST_DONE,     8'h00, 5'd14}}
  };

  ordered_entry_queue_with_match dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_proc_index     (in_proc_index),
    .in_page_number    (in_page_number),
    .in_frame_number   (in_frame_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_removed_frame (out_removed_frame),
    .out_occupancy     (out_occupancy)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Apply one command to the held queue and return the result it gives
  function automatic result_t run_command(cmd_t op, entry_t key);
    result_t r;
    int      hit;
    r.status  = ST_NOTFOUND;
    r.removed = '0;
    hit       = -1;
    case (op)
      CMD_ADD: begin
        if (held.size() < QUEUE_DEPTH) begin
          held.push_back(key);
          r.status = ST_DONE;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_POP: begin
        if (held.size() > 0) begin
          void'(held.pop_front());
          r.status = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        foreach (held[k]) if (hit < 0 && held[k] == key) hit = k;
        if (hit >= 0) begin
          r.removed = held[hit].frame;
          held.delete(hit);
          r.status = ST_DONE;
        end
      end
      default: begin
        foreach (held[k]) if (held[k].frame == key.frame) r.status = ST_DONE;
      end
    endcase
    r.occ = 5'(held.size());
    return r;
  endfunction

  // Small values often, so that keys collide, with the extremes mixed in
  function automatic field_t pick_field();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return field_t'($urandom_range(0, 3));
    if (sel < 55) return 8'hff;
    return field_t'($urandom_range(0, 255));
  endfunction

  // Offer one beat, idling first at random, and hold it until taken
  task automatic offer(cmd_t op, entry_t e, logic typed, result_t want);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= op;
    in_proc_index   <= e.proc;
    in_page_number  <= e.page;
    in_frame_number <= e.frame;
    row_typed       <= typed;
    row_want        <= want;
    n_offered++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stimulus: reset, directed plan, then random traffic in fill and drain phases
  initial begin : stimulus
    cmd_t   op;
    entry_t e;
    bit     filling;
    int     phase_left;
    int     sel;
    in_valid        <= 1'b0;
    in_command      <= CMD_ADD;
    in_proc_index   <= '0;
    in_page_number  <= '0;
    in_frame_number <= '0;
    row_typed       <= 1'b0;
    row_want        <= '0;
    rst_n           <= 1'b0;
    calm            = 1'b0;
    filling         = 1'b1;
    phase_left      = 100;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      repeat (plan[i].reps) offer(plan[i].op, plan[i].e, plan[i].typed, plan[i].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n_offered >= CALM_FROM && n_offered < CALM_TO);
      // drain everything once before carrying on
      if (n_offered == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (--phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(60, 200);
      end
      sel = $urandom_range(0, 99);
      if (filling)
        op = (sel < 55) ? CMD_ADD : (sel < 65) ? CMD_POP : (sel < 85) ? CMD_REMOVE : CMD_CONTAINS;
      else
        op = (sel < 20) ? CMD_ADD : (sel < 50) ? CMD_POP : (sel < 80) ? CMD_REMOVE : CMD_CONTAINS;
      e = {pick_field(), pick_field(), pick_field()};
      // aim removes at held entries most of the time and lookups half of the time
      if (held.size() > 0) begin
        if (op == CMD_REMOVE && $urandom_range(0, 99) < 65) begin
          e = held[$urandom_range(0, held.size() - 1)];
          if ($urandom_range(0, 99) < 15) e ^= 24'(1) << $urandom_range(0, 23);
        end else if (op == CMD_CONTAINS && $urandom_range(0, 99) < 50) begin
          e.frame = held[$urandom_range(0, held.size() - 1)].frame;
        end
      end
      offer(op, e, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // wait out the last results, then keep watching for stray beats
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("results outstanding at end: expected %0d, got %0d", 0, pending_results.size());
      errors++;
    end
    $display("%0d commands: %0d adds on a full queue, %0d remove hits, %0d remove misses,",
             n_cmds, n_full, n_rm_hit, n_rm_miss);
    $display("%0d contains hits, %0d pops on an empty queue", n_has_hit, n_empty_pop);
    if (errors == 0) begin
      $display("ordered_entry_queue_with_match regression: pass");
    end else begin
      $display("ordered_entry_queue_with_match regression: fail");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, and a calm stretch
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && n_offered >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        held_off = 1'b1;
        out_ready <= 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Predict each accepted command; typed plan rows override the prediction
  always @(posedge clk) begin : predict
    result_t r;
    if (rst_n && in_valid && in_ready) begin
      r = run_command(cmd_t'(in_command), {in_proc_index, in_page_number, in_frame_number});
      n_cmds++;
      if (r.status == ST_FULL) n_full++;
      if (in_command == CMD_REMOVE) begin
        if (r.status == ST_DONE) n_rm_hit++;
        else n_rm_miss++;
      end
      if (in_command == CMD_CONTAINS && r.status == ST_DONE) n_has_hit++;
      if (in_command == CMD_POP && r.status == ST_NOTFOUND) n_empty_pop++;
      pending_results.push_back(row_typed ? row_want : r);
    end
  end

  // Score each result beat against the oldest expectation
  always @(posedge clk) begin : score
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_removed_frame !== want.removed) begin
          $error("removed_frame: expected %0h, got %0h", want.removed, out_removed_frame);
          errors++;
        end
        if (out_occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, out_occupancy);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STUCK_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
        $display("ordered_entry_queue_with_match regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
